FILE: rtl/llp_pkg.sv
// shared constants, types and helpers of the linked list node pool
package llp_pkg;

    localparam int DEPTH       = 1024;
    localparam int IDX_W       = 10;
    localparam int VAL_W       = 32;
    localparam int CNT_W       = IDX_W + 1;
    localparam int POOL_CAP    = (DEPTH < (1 << IDX_W)) ? DEPTH : (1 << IDX_W);
    localparam int ADDR_W      = $clog2(POOL_CAP);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_UNALLOC = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        K_PUSH,
        K_POP,
        K_POP_EMPTY
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [IDX_W-1:0]   head;
        logic [VAL_W-1:0]   value;
    } q_entry_t;

    typedef struct packed {
        logic       valid;
        q_entry_t   entry;
    } q_out_t;

    // node index to memory address; live nodes are always below the pool capacity
    function automatic logic [ADDR_W-1:0] slot(input logic [IDX_W-1:0] idx);
        return idx[ADDR_W-1:0];
    endfunction

endpackage

FILE: rtl/llp_req_if.sv
// request channel of the node pool
interface llp_req_if;
    logic                           valid;
    logic                           ready;
    logic                           operation;
    logic [llp_pkg::IDX_W-1:0]      head;
    logic [llp_pkg::VAL_W-1:0]      value;

    modport source (output valid, output operation, output head, output value, input ready);
    modport sink   (input valid, input operation, input head, input value, output ready);
endinterface

FILE: rtl/llp_rsp_if.sv
// response channel of the node pool
interface llp_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [llp_pkg::IDX_W-1:0]      new_head;
    logic [llp_pkg::VAL_W-1:0]      popped_value;
    logic [1:0]                     status;

    modport source (output valid, output new_head, output popped_value, output status,
                    input ready);
    modport sink   (input valid, input new_head, input popped_value, input status,
                    output ready);
endinterface

FILE: rtl/llp_ram.sv
// generic single write port, single read port ram with registered read
module llp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [$clog2(DEPTH)-1:0]    waddr,
    input  logic [WIDTH-1:0]            wdata,
    input  logic                        re,
    input  logic [$clog2(DEPTH)-1:0]    raddr,
    output logic [WIDTH-1:0]            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/llp_front.sv
// front end: takes request items, classifies them and queues them for the back end
module llp_front (
    input  logic                clk,
    input  logic                rst_n,
    llp_req_if.sink             request,
    output llp_pkg::q_out_t     q_out,
    input  logic                q_pop
);

    logic [llp_pkg::QCNT_W-1:0] count_reg, count_next;
    logic [llp_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [llp_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    llp_pkg::q_entry_t          entry_reg [llp_pkg::QUEUE_DEPTH];
    llp_pkg::q_entry_t          decoded;
    logic                       push;

    always_comb
    begin
        decoded.head  = request.head;
        decoded.value = request.value;
        if (request.operation == llp_pkg::OP_POP)
        begin
            decoded.kind = (request.head == '0) ? llp_pkg::K_POP_EMPTY : llp_pkg::K_POP;
        end
        else
        begin
            decoded.kind = llp_pkg::K_PUSH;
        end
    end

    assign request.ready = (count_reg != llp_pkg::QCNT_W'(llp_pkg::QUEUE_DEPTH));
    assign push          = request.valid && request.ready;

    always_comb
    begin
        wr_ptr_next = push  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + llp_pkg::QCNT_W'(push) - llp_pkg::QCNT_W'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= decoded;
        end
    end

    assign q_out.valid = (count_reg != '0);
    assign q_out.entry = entry_reg[rd_ptr_reg];

endmodule

FILE: rtl/llp_back.sv
// back end: checks each queued item against the pool state and runs it on the node memories
module llp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  llp_pkg::q_out_t     q_in,
    output logic                q_pop,
    llp_rsp_if.source           response
);

    typedef enum logic {
        S_IDLE,
        S_WB
    } state_t;

    state_t                         state_reg, state_next;
    logic [llp_pkg::IDX_W-1:0]      free_head_reg, free_head_next;
    logic [llp_pkg::CNT_W-1:0]      used_count_reg, used_count_next;
    llp_pkg::kind_t                 cur_kind_reg, cur_kind_next;
    logic [llp_pkg::IDX_W-1:0]      cur_head_reg, cur_head_next;
    logic [llp_pkg::VAL_W-1:0]      cur_value_reg, cur_value_next;
    logic [llp_pkg::IDX_W-1:0]      node_reg, node_next;
    logic                           from_free_reg, from_free_next;
    logic                           out_valid_reg, out_valid_next;
    logic [llp_pkg::IDX_W-1:0]      out_head_reg, out_head_next;
    logic [llp_pkg::VAL_W-1:0]      out_value_reg, out_value_next;
    llp_pkg::status_t               out_status_reg, out_status_next;

    logic                           out_free;
    logic                           head_unalloc;
    logic                           free_avail;
    logic                           ram_we, ram_re;
    logic [llp_pkg::ADDR_W-1:0]     ram_waddr, ram_raddr;
    logic [llp_pkg::IDX_W-1:0]      link_wdata, link_rdata;
    logic [llp_pkg::VAL_W-1:0]      value_wdata, value_rdata;

    llp_ram #(.WIDTH(llp_pkg::IDX_W), .DEPTH(llp_pkg::POOL_CAP)) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (link_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (link_rdata)
    );

    llp_ram #(.WIDTH(llp_pkg::VAL_W), .DEPTH(llp_pkg::POOL_CAP)) u_value_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (value_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (value_rdata)
    );

    assign out_free     = !out_valid_reg || response.ready;
    assign head_unalloc = ({1'b0, q_in.entry.head} >= used_count_reg);
    assign free_avail   = (free_head_reg != '0);

    always_comb
    begin
        state_next      = state_reg;
        free_head_next  = free_head_reg;
        used_count_next = used_count_reg;
        cur_kind_next   = cur_kind_reg;
        cur_head_next   = cur_head_reg;
        cur_value_next  = cur_value_reg;
        node_next       = node_reg;
        from_free_next  = from_free_reg;
        out_valid_next  = out_valid_reg && !response.ready;
        out_head_next   = out_head_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        q_pop           = 1'b0;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_waddr       = llp_pkg::slot(node_reg);
        ram_raddr       = llp_pkg::slot(q_in.entry.head);
        link_wdata      = cur_head_reg;
        value_wdata     = cur_value_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_in.valid)
                begin
                    unique case (q_in.entry.kind)
                        llp_pkg::K_POP_EMPTY:
                        begin
                            if (out_free)
                            begin
                                q_pop           = 1'b1;
                                out_valid_next  = 1'b1;
                                out_head_next   = q_in.entry.head;
                                out_value_next  = '0;
                                out_status_next = llp_pkg::ST_EMPTY;
                            end
                        end
                        llp_pkg::K_POP:
                        begin
                            if (head_unalloc)
                            begin
                                if (out_free)
                                begin
                                    q_pop           = 1'b1;
                                    out_valid_next  = 1'b1;
                                    out_head_next   = q_in.entry.head;
                                    out_value_next  = '0;
                                    out_status_next = llp_pkg::ST_UNALLOC;
                                end
                            end
                            else
                            begin
                                q_pop         = 1'b1;
                                ram_re        = 1'b1;
                                ram_raddr     = llp_pkg::slot(q_in.entry.head);
                                cur_kind_next = q_in.entry.kind;
                                cur_head_next = q_in.entry.head;
                                state_next    = S_WB;
                            end
                        end
                        llp_pkg::K_PUSH:
                        begin
                            if (head_unalloc || (free_avail && free_head_reg == q_in.entry.head))
                            begin
                                if (out_free)
                                begin
                                    q_pop           = 1'b1;
                                    out_valid_next  = 1'b1;
                                    out_head_next   = q_in.entry.head;
                                    out_value_next  = '0;
                                    out_status_next = llp_pkg::ST_UNALLOC;
                                end
                            end
                            else if (!free_avail &&
                                     used_count_reg >= llp_pkg::CNT_W'(llp_pkg::POOL_CAP))
                            begin
                                if (out_free)
                                begin
                                    q_pop           = 1'b1;
                                    out_valid_next  = 1'b1;
                                    out_head_next   = q_in.entry.head;
                                    out_value_next  = '0;
                                    out_status_next = llp_pkg::ST_FULL;
                                end
                            end
                            else
                            begin
                                q_pop          = 1'b1;
                                cur_kind_next  = q_in.entry.kind;
                                cur_head_next  = q_in.entry.head;
                                cur_value_next = q_in.entry.value;
                                from_free_next = free_avail;
                                state_next     = S_WB;
                                if (free_avail)
                                begin
                                    // fetch the successor of the free list head
                                    node_next = free_head_reg;
                                    ram_re    = 1'b1;
                                    ram_raddr = llp_pkg::slot(free_head_reg);
                                end
                                else
                                begin
                                    node_next       = used_count_reg[llp_pkg::IDX_W-1:0];
                                    used_count_next = used_count_reg + llp_pkg::CNT_W'(1);
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_WB:
            begin
                if (out_free)
                begin
                    ram_we         = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (cur_kind_reg == llp_pkg::K_POP)
                    begin
                        // freed node goes on top of the free list
                        ram_waddr       = llp_pkg::slot(cur_head_reg);
                        link_wdata      = free_head_reg;
                        value_wdata     = '0;
                        free_head_next  = cur_head_reg;
                        out_head_next   = link_rdata;
                        out_value_next  = value_rdata;
                        out_status_next = llp_pkg::ST_OK;
                    end
                    else
                    begin
                        ram_waddr       = llp_pkg::slot(node_reg);
                        link_wdata      = cur_head_reg;
                        value_wdata     = cur_value_reg;
                        if (from_free_reg)
                        begin
                            free_head_next = link_rdata;
                        end
                        out_head_next   = node_reg;
                        out_value_next  = '0;
                        out_status_next = llp_pkg::ST_OK;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            free_head_reg  <= '0;
            used_count_reg <= llp_pkg::CNT_W'(1);
            cur_kind_reg   <= llp_pkg::K_PUSH;
            cur_head_reg   <= '0;
            cur_value_reg  <= '0;
            node_reg       <= '0;
            from_free_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_head_reg   <= '0;
            out_value_reg  <= '0;
            out_status_reg <= llp_pkg::ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            free_head_reg  <= free_head_next;
            used_count_reg <= used_count_next;
            cur_kind_reg   <= cur_kind_next;
            cur_head_reg   <= cur_head_next;
            cur_value_reg  <= cur_value_next;
            node_reg       <= node_next;
            from_free_reg  <= from_free_next;
            out_valid_reg  <= out_valid_next;
            out_head_reg   <= out_head_next;
            out_value_reg  <= out_value_next;
            out_status_reg <= out_status_next;
        end
    end

    assign response.valid        = out_valid_reg;
    assign response.new_head     = out_head_reg;
    assign response.popped_value = out_value_reg;
    assign response.status       = out_status_reg;

`ifndef SYNTHESIS
    a_used_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        used_count_reg >= llp_pkg::CNT_W'(1) &&
        used_count_reg <= llp_pkg::CNT_W'(llp_pkg::POOL_CAP))
        else $error("used count outside pool range");

    a_free_head_live: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, free_head_reg} < used_count_reg)
        else $error("free list head beyond high-water mark");

    a_pop_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_in.valid)
        else $error("queue popped while empty");

    a_wb_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && state_next == S_WB) |-> q_pop)
        else $error("memory phase entered without taking an item");
`endif

endmodule

FILE: rtl/linked_list_pool_free_list_unit.sv
// top level of the linked list node pool with free list
// A pool of nodes that holds any number of singly linked stacks, each named by its head
// index (0 is the empty list). A push item stores its value in a node taken from the
// free list, or else from the next never-used slot, links it in front of the given head
// and returns the node as the new head. A pop item returns the head node's value and its
// successor and puts the node back on the free list. Each request item gives exactly one
// response item with status ok, pool full, pop of empty head, or head not allocated; on
// error the head comes back unchanged, popped_value is zero and the pool is not touched.
// Items that end in an error are answered from the idle state; good pushes and pops also
// pass through a write-back state, where the link and value memories are written after
// any registered read issued in the idle state; the back end takes no new item until it
// has left write-back. A two-item queue between the request side and the memory
// sequencer, and a response register, let either side stall without blocking the other.
// Every node below the high-water mark is written before it can be read, so no response
// depends on the power-up contents of the node memories.
module linked_list_pool_free_list_unit (
    input  logic        clk,
    input  logic        rst_n,
    llp_req_if.sink     request,
    llp_rsp_if.source   response
);

    // classified items waiting for the memory sequencer
    llp_pkg::q_out_t    q_bus;
    logic               q_pop;

    // request side: decode and queue
    llp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .q_out   (q_bus),
        .q_pop   (q_pop)
    );

    // memory side: pool state, node memories and response register
    llp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_in     (q_bus),
        .q_pop    (q_pop),
        .response (response)
    );

endmodule
